[sv/press_gesture_bar_controller_defines.svh]
// ---------------------------------------------------------------------------
// Press gesture bar controller assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PRESS_GESTURE_BAR_CONTROLLER_DEFINES_SVH
`define PRESS_GESTURE_BAR_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset
`define PGBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pgbc assertion failed");

// Next-cycle implication, sampled on the block clock, off during reset
`define PGBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pgbc assertion failed");

`endif

[sv/pgbc_pkg.sv]
// ---------------------------------------------------------------------------
// Press gesture bar controller package
// Widths, state and gesture codes, register indexes and the bar decoder.
// ---------------------------------------------------------------------------
package pgbc_pkg;

    localparam int BAR_LEDS  = 16;
    localparam int LIT_W     = 5;
    localparam int TICK_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int STATE_W   = 4;
    localparam int GEST_W    = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 8'd1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd300;
    localparam logic [CFG_W-1:0] GAP_RESET        = 16'd200;

    // machine states
    localparam logic [STATE_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [STATE_W-1:0] ST_PRESS1    = 4'd1;
    localparam logic [STATE_W-1:0] ST_LONG1     = 4'd2;
    localparam logic [STATE_W-1:0] ST_GAP_SHORT = 4'd3;
    localparam logic [STATE_W-1:0] ST_GAP_LONG  = 4'd4;
    localparam logic [STATE_W-1:0] ST_PRESS_S2  = 4'd5;
    localparam logic [STATE_W-1:0] ST_PRESS_L2  = 4'd6;
    localparam logic [STATE_W-1:0] ST_LONG_S2   = 4'd7;
    localparam logic [STATE_W-1:0] ST_LONG_L2   = 4'd8;

    // gesture codes
    localparam logic [GEST_W-1:0] G_NONE = 3'd0;
    localparam logic [GEST_W-1:0] G_S    = 3'd1;
    localparam logic [GEST_W-1:0] G_L    = 3'd2;
    localparam logic [GEST_W-1:0] G_SS   = 3'd3;
    localparam logic [GEST_W-1:0] G_SL   = 3'd4;
    localparam logic [GEST_W-1:0] G_LS   = 3'd5;
    localparam logic [GEST_W-1:0] G_LL   = 3'd6;

    // thermometer bar, MSB lit first; levels above the bar length light all
    function automatic logic [BAR_LEDS-1:0] bar_pattern(input logic [LIT_W-1:0] lit);
        logic [BAR_LEDS-1:0] ones;
        ones = '1;
        return ~(ones >> lit);
    endfunction

endpackage

[sv/press_gesture_bar_controller.sv]
// ---------------------------------------------------------------------------
// Press gesture bar controller
// Classifies button presses into gestures and drives a 16-LED bar.
// ---------------------------------------------------------------------------
// Each input item is one button poll (tick time, button level, clear request)
// and gives exactly one result item: the bar as two bytes, the lit LED count
// and the gesture completed at that poll. The block takes one item per clock
// cycle while the result is not stalled. An item is registered on entry, and
// its result is registered when the entry register advances into the result
// register. The rate is set by the state update between the two registers
// (two 32-bit elapsed-time compares and the gesture step). Result stall holds
// the output register and pushes back on the input once the entry register is
// also full. Configuration writes are always ready and take effect at once.
`include "press_gesture_bar_controller_defines.svh"

module press_gesture_bar_controller
    import pgbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TICK_W-1:0]    i_now_ticks,
    input  logic                 i_button_down,
    input  logic                 i_clear_request,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_bar_upper,
    output logic [7:0]           o_bar_lower,
    output logic [LIT_W-1:0]     o_lit_count,
    output logic [GEST_W-1:0]    o_gesture
);

    // configuration registers
    logic [CFG_W-1:0] r_long_press_ticks;
    logic [CFG_W-1:0] r_gap_ticks;

    // entry register
    logic              r_s1_valid;
    logic [TICK_W-1:0] r_s1_now;
    logic              r_s1_down;
    logic              r_s1_clr;

    // machine state
    logic [STATE_W-1:0] r_state, n_state;
    logic [LIT_W-1:0]   r_lit, n_lit;
    logic [TICK_W-1:0]  r_press, n_press;
    logic [TICK_W-1:0]  r_rel, n_rel;

    // result register
    logic                r_out_valid;
    logic [BAR_LEDS-1:0] r_bar;
    logic [LIT_W-1:0]    r_lit_out;
    logic [GEST_W-1:0]   r_gesture;

    logic              s2_adv;
    logic              s2_fire;
    logic              long_to;
    logic              gap_to;
    logic [GEST_W-1:0] n_gesture;
    logic [TICK_W-1:0] press_elapsed;
    logic [TICK_W-1:0] rel_elapsed;

    // handshake
    assign o_cfg_ready = 1'b1;
    assign s2_adv      = !r_out_valid || !i_out_stall;
    assign s2_fire     = r_s1_valid && s2_adv;
    assign o_in_stall  = r_s1_valid && !s2_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= LONG_PRESS_RESET;
            r_gap_ticks        <= GAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LONG_PRESS: r_long_press_ticks <= i_cfg_data;
                CFG_GAP:        r_gap_ticks        <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_now  <= i_now_ticks;
            r_s1_down <= i_button_down;
            r_s1_clr  <= i_clear_request;
        end
    end

    // elapsed times, modulo the tick width
    assign press_elapsed = r_s1_now - r_press;
    assign rel_elapsed   = r_s1_now - r_rel;
    assign long_to = press_elapsed >= {{(TICK_W-CFG_W){1'b0}}, r_long_press_ticks};
    assign gap_to  = rel_elapsed   >= {{(TICK_W-CFG_W){1'b0}}, r_gap_ticks};

    // gesture machine and bar update
    always_comb begin
        n_state   = r_state;
        n_lit     = r_lit;
        n_press   = r_press;
        n_rel     = r_rel;
        n_gesture = G_NONE;

        case (r_state)
            ST_PRESS1: begin
                if (long_to) begin
                    n_state = ST_LONG1;
                end else if (!r_s1_down) begin
                    n_rel   = r_s1_now;
                    n_state = ST_GAP_SHORT;
                end
            end
            ST_LONG1: begin
                if (!r_s1_down) begin
                    n_rel   = r_s1_now;
                    n_state = ST_GAP_LONG;
                end
            end
            ST_GAP_SHORT, ST_GAP_LONG: begin
                if (gap_to) begin
                    n_gesture = (r_state == ST_GAP_SHORT) ? G_S : G_L;
                    n_state   = ST_IDLE;
                end else if (r_s1_down) begin
                    n_press = r_s1_now;
                    n_state = (r_state == ST_GAP_SHORT) ? ST_PRESS_S2 : ST_PRESS_L2;
                end
            end
            ST_PRESS_S2, ST_PRESS_L2: begin
                if (long_to) begin
                    n_state = (r_state == ST_PRESS_S2) ? ST_LONG_S2 : ST_LONG_L2;
                end else if (!r_s1_down) begin
                    n_gesture = (r_state == ST_PRESS_S2) ? G_SS : G_LS;
                    n_state   = ST_IDLE;
                end
            end
            ST_LONG_S2, ST_LONG_L2: begin
                if (!r_s1_down) begin
                    n_gesture = (r_state == ST_LONG_S2) ? G_SL : G_LL;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                // idle, and any unused code
                if (r_s1_down) begin
                    n_press = r_s1_now;
                    n_state = ST_PRESS1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
        endcase

        // bar change for the completed gesture; full and empty bars saturate
        case (n_gesture)
            G_S:     if (r_lit < LIT_W'(BAR_LEDS)) n_lit = r_lit + 1'b1;
            G_SS:    if (r_lit != '0) n_lit = r_lit - 1'b1;
            G_L:     n_lit = LIT_W'(8);
            G_SL:    n_lit = LIT_W'(6);
            G_LS:    n_lit = LIT_W'(BAR_LEDS);
            G_LL:    n_lit = '0;
            default: ;
        endcase

        // clear keeps the gesture code but zeroes all state
        if (r_s1_clr) begin
            n_state = ST_IDLE;
            n_lit   = '0;
            n_press = '0;
            n_rel   = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lit   <= '0;
            r_press <= '0;
            r_rel   <= '0;
        end else if (s2_fire) begin
            r_state <= n_state;
            r_lit   <= n_lit;
            r_press <= n_press;
            r_rel   <= n_rel;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_bar     <= bar_pattern(n_lit);
            r_lit_out <= n_lit;
            r_gesture <= n_gesture;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bar_upper = r_bar[BAR_LEDS-1:BAR_LEDS/2];
    assign o_bar_lower = r_bar[BAR_LEDS/2-1:0];
    assign o_lit_count = r_lit_out;
    assign o_gesture   = r_gesture;

    // checks
    `PGBC_ASSERT_NOW(a_lit_range, r_out_valid, r_lit_out <= LIT_W'(BAR_LEDS))
    `PGBC_ASSERT_NOW(a_bar_matches_count, r_out_valid,
        $countones(r_bar) == int'(r_lit_out))
    `PGBC_ASSERT_NOW(a_gesture_ends_idle, r_out_valid && (r_gesture != G_NONE),
        r_state == ST_IDLE)
    `PGBC_ASSERT_NEXT(a_stall_holds_entry, o_in_stall, r_s1_valid)

endmodule
